[sv/spq_pkg.sv]
// spq_pkg: shared widths, operation and status codes, cell control type
// for the sorted priority queue. No dependencies.
package spq_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned CAPACITY_DEF = 16;

  // operation codes on kind_i; the fourth code is a no-op
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert of a value into a non-full queue
    logic pop;  // pop from a non-empty queue
  } cell_ctrl_t;

endpackage

[sv/spq_cell.sv]
// spq_cell: one slot of the sorted row. Cell 0 holds the minimum; larger
// indexes hold larger values. Depends on spq_pkg.
module spq_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned CNTW = 5
) (
  input  logic                               clk_i,
  input  spq_pkg::cell_ctrl_t                ctrl_i,
  input  logic        [CNTW-1:0]             count_i,
  input  logic signed [spq_pkg::DATA_W-1:0]  ins_value_i,
  input  logic                               lower_lt_i,   // lower neighbor < new value
  input  logic signed [spq_pkg::DATA_W-1:0]  lower_value_i,
  input  logic signed [spq_pkg::DATA_W-1:0]  upper_value_i,
  output logic                               lt_o,
  output logic signed [spq_pkg::DATA_W-1:0]  value_o
);

  logic signed [spq_pkg::DATA_W-1:0] value_q, value_d;
  logic                              occupied;

  // slot is live when it lies below the fill count
  assign occupied = (count_i > CNTW'(IDX));
  assign lt_o     = occupied && (value_q < ins_value_i);
  assign value_o  = value_q;

  // insert: keep if smaller, take the new value at the boundary, else
  // shift up from the lower neighbor; pop: shift down from above
  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (lt_o) begin
        value_d = value_q;
      end else if (lower_lt_i) begin
        value_d = ins_value_i;
      end else begin
        value_d = lower_value_i;
      end
    end else if (ctrl_i.pop) begin
      value_d = upper_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

[sv/sorted_priority_queue.sv]
// Sorted priority queue: done_o rises in the cycle after start_i, one
// operation accepted every cycle (busy_o stays low); set by one row of
// compare-and-shift cells updating in parallel. The receiver cannot stall.
// Reset clears the fill count and the result strobe; slot data is not reset.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic        [spq_pkg::KIND_W-1:0] kind_i,
  input  logic signed [spq_pkg::DATA_W-1:0] value_i,
  output logic                              done_o,
  output logic        [spq_pkg::STATUS_W-1:0] status_o,
  output logic signed [spq_pkg::DATA_W-1:0] popped_value_o,
  output logic signed [spq_pkg::DATA_W-1:0] min_value_o,
  output logic        [spq_pkg::COUNT_W-1:0] count_o,
  output logic                              is_empty_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                              accept;
  logic                              ins_ok, pop_ok;
  spq_pkg::cell_ctrl_t               ctrl;
  logic        [CntW-1:0]            count_q, count_d;
  logic signed [spq_pkg::DATA_W-1:0] min_next;
  logic        [spq_pkg::STATUS_W-1:0] status_d;

  logic                              done_q;
  logic        [spq_pkg::STATUS_W-1:0] status_q;
  logic signed [spq_pkg::DATA_W-1:0] popped_q, min_q;
  logic        [spq_pkg::COUNT_W-1:0] res_count_q;
  logic                              empty_q;

  logic                              cell_lt  [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] cell_val [CAPACITY];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // decode the operation against the fill count
  always_comb begin
    ins_ok   = 1'b0;
    pop_ok   = 1'b0;
    count_d  = count_q;
    status_d = spq_pkg::STATUS_OK;
    if (accept) begin
      unique case (spq_pkg::kind_e'(kind_i))
        spq_pkg::KIND_INSERT: begin
          if (count_q < CntW'(CAPACITY)) begin
            ins_ok  = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            status_d = spq_pkg::STATUS_FULL;
          end
        end
        spq_pkg::KIND_POP: begin
          if (count_q != '0) begin
            pop_ok  = 1'b1;
            count_d = count_q - CntW'(1);
          end else begin
            status_d = spq_pkg::STATUS_EMPTY;
          end
        end
        spq_pkg::KIND_CLEAR: count_d = '0;
        default:             count_d = count_q;
      endcase
    end
  end

  assign ctrl.ins = ins_ok;
  assign ctrl.pop = pop_ok;

  // row of cells, cell 0 holds the minimum
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic                              lower_lt;
    logic signed [spq_pkg::DATA_W-1:0] lower_val, upper_val;

    if (j == 0) begin : g_first
      assign lower_lt  = 1'b1;
      assign lower_val = value_i;
    end else begin : g_mid
      assign lower_lt  = cell_lt[j-1];
      assign lower_val = cell_val[j-1];
    end

    if (j == CAPACITY - 1) begin : g_last
      assign upper_val = '0;
    end else begin : g_below
      assign upper_val = cell_val[j+1];
    end

    spq_cell #(
      .IDX  (j),
      .CNTW (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .ins_value_i   (value_i),
      .lower_lt_i    (lower_lt),
      .lower_value_i (lower_val),
      .upper_value_i (upper_val),
      .lt_o          (cell_lt[j]),
      .value_o       (cell_val[j])
    );
  end

  // next content of cell 0, i.e. the minimum after this step
  always_comb begin
    if (ins_ok) begin
      min_next = cell_lt[0] ? cell_val[0] : value_i;
    end else if (pop_ok) begin
      min_next = cell_val[1];
    end else begin
      min_next = cell_val[0];
    end
  end

  // fill count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      popped_q    <= pop_ok ? cell_val[0] : '0;
      min_q       <= (count_d != '0) ? min_next : '0;
      res_count_q <= spq_pkg::COUNT_W'(count_d);
      empty_q     <= (count_d == '0);
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign min_value_o    = min_q;
  assign count_o        = res_count_q;
  assign is_empty_o     = empty_q;

endmodule

[sv/spq_checker.sv]
// spq_checker: port-level assertions for sorted_priority_queue, bound to
// the top level below. Depends on spq_pkg.
module spq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic                                done_o,
  input logic        [spq_pkg::STATUS_W-1:0] status_o,
  input logic signed [spq_pkg::DATA_W-1:0]   popped_value_o,
  input logic signed [spq_pkg::DATA_W-1:0]   min_value_o,
  input logic        [spq_pkg::COUNT_W-1:0]  count_o,
  input logic                                is_empty_o
);

  // every transfer gives one result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("no result after accepted transfer");

  // no result without a transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o))
    else $error("result strobe without transfer");

  // empty queue reports zero count and zero minimum
  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (count_o == '0 && min_value_o == '0))
    else $error("empty result with nonzero count or minimum");

  // failed operation removes nothing
  a_fail_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != spq_pkg::STATUS_OK) |-> (popped_value_o == '0))
    else $error("popped value on failed operation");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .status_o       (status_o),
  .popped_value_o (popped_value_o),
  .min_value_o    (min_value_o),
  .count_o        (count_o),
  .is_empty_o     (is_empty_o)
);

[test/sorted_priority_queue_test.sv]
// Self-checking testbench for sorted_priority_queue: directed and random insert, pop,
// clear and no-op commands, checked against an in-bench model of the sorted store.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module sorted_priority_queue_test;

  localparam int unsigned CAPACITY    = spq_pkg::CAPACITY_DEF;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          MAX_REPORTS = 10;
  // fourth code on kind_i, a no-op
  localparam logic [spq_pkg::KIND_W-1:0] KIND_NOP = 2'd3;

  // one queue report, as seen on the result ports
  typedef struct packed {
    logic        [spq_pkg::STATUS_W-1:0] status;
    logic signed [spq_pkg::DATA_W-1:0]   popped;
    logic signed [spq_pkg::DATA_W-1:0]   min_value;
    logic        [spq_pkg::COUNT_W-1:0]  count;
    logic                                is_empty;
  } queue_report_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                start_i;
  logic                                busy_o;
  logic        [spq_pkg::KIND_W-1:0]   kind_i;
  logic signed [spq_pkg::DATA_W-1:0]   value_i;
  logic                                done_o;
  logic        [spq_pkg::STATUS_W-1:0] status_o;
  logic signed [spq_pkg::DATA_W-1:0]   popped_value_o;
  logic signed [spq_pkg::DATA_W-1:0]   min_value_o;
  logic        [spq_pkg::COUNT_W-1:0]  count_o;
  logic                                is_empty_o;

  // model of the store: slot 0 largest, slot fill-1 smallest
  logic signed [spq_pkg::DATA_W-1:0] model_slots [CAPACITY];
  int unsigned                       model_fill;

  queue_report_t expected_reports[$];
  int            mismatches;
  int            cycles;

  sorted_priority_queue #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .min_value_o   (min_value_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // apply one command to the model and return the report it should produce
  function automatic queue_report_t predict_queue_op(
    input logic        [spq_pkg::KIND_W-1:0] kind,
    input logic signed [spq_pkg::DATA_W-1:0] value
  );
    queue_report_t rep;
    int unsigned   pos;
    rep = '0;
    rep.status = spq_pkg::STATUS_OK;
    if (kind == spq_pkg::KIND_INSERT) begin
      if (model_fill >= CAPACITY) begin
        rep.status = spq_pkg::STATUS_FULL;
      end else begin
        // new value goes behind every stored value >= it
        pos = 0;
        while (pos < model_fill && value <= model_slots[pos]) pos++;
        for (int unsigned i = model_fill; i > pos; i--) model_slots[i] = model_slots[i-1];
        model_slots[pos] = value;
        model_fill++;
      end
    end else if (kind == spq_pkg::KIND_POP) begin
      if (model_fill == 0) begin
        rep.status = spq_pkg::STATUS_EMPTY;
      end else begin
        model_fill--;
        rep.popped = model_slots[model_fill];
      end
    end else if (kind == spq_pkg::KIND_CLEAR) begin
      model_fill = 0;
    end
    if (model_fill > 0) rep.min_value = model_slots[model_fill-1];
    rep.count    = model_fill[spq_pkg::COUNT_W-1:0];
    rep.is_empty = (model_fill == 0);
    return rep;
  endfunction

  // one command transfer; start_i stays high until a gap lowers it
  task automatic send_op(input logic        [spq_pkg::KIND_W-1:0] kind,
                         input logic signed [spq_pkg::DATA_W-1:0] value);
    @(negedge clk_i);
    start_i <= 1'b1;
    kind_i  <= kind;
    value_i <= value;
    do @(posedge clk_i); while (busy_o);
    expected_reports.push_back(predict_queue_op(kind, value));
  endtask

  // random sender gaps: start_i is lowered again while a roll below idle_pct percent comes up
  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // hold off until every report has come back
  task automatic drain_queue();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  // values: extremes, clustered small values for ties, and full random
  function automatic logic signed [spq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3:    return $signed($urandom_range(8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // report checker
  always @(posedge clk_i) begin
    queue_report_t got;
    queue_report_t want;
    if (rst_ni && done_o) begin
      got = '{status_o, popped_value_o, min_value_o, count_o, is_empty_o};
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected report: status %0d popped %0d min %0d count %0d empty %0b",
                   got.status, got.popped, got.min_value, got.count, got.is_empty);
      end else begin
        want = expected_reports.pop_front();
        if (got.status !== want.status || got.popped !== want.popped ||
            got.min_value !== want.min_value || got.count !== want.count ||
            got.is_empty !== want.is_empty) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: status %0d/%0d popped %0d/%0d min %0d/%0d ",
                      "count %0d/%0d empty %0b/%0b (exp/act)"},
                     want.status, got.status, want.popped, got.popped,
                     want.min_value, got.min_value, want.count, got.count,
                     want.is_empty, got.is_empty);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sorted_priority_queue] ERROR");
      $finish;
    end
  end

  // edges of the behavior: empty pops, extremes, ties, full, clear, last pop
  task automatic test_directed();
    send_op(spq_pkg::KIND_POP, 32'sd0);
    send_op(KIND_NOP, 32'sh7FFF_FFFF);
    send_op(spq_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
    send_op(spq_pkg::KIND_INSERT, 32'sh8000_0000);
    send_op(spq_pkg::KIND_INSERT, 32'sd0);
    send_op(spq_pkg::KIND_INSERT, -32'sd1);
    send_op(spq_pkg::KIND_INSERT, 32'sh8000_0000);
    send_op(spq_pkg::KIND_POP, 32'sh5555_5555);
    // fill to capacity with ties mixed in
    while (model_fill < CAPACITY)
      send_op(spq_pkg::KIND_INSERT, ($urandom_range(1)) ? -32'sd1 : pick_value());
    send_op(spq_pkg::KIND_INSERT, 32'sh8000_0000);
    send_op(spq_pkg::KIND_CLEAR, 32'shAAAA_AAAA);
    send_op(spq_pkg::KIND_INSERT, 32'sd1);
    send_op(spq_pkg::KIND_POP, 32'sd0);
    send_op(spq_pkg::KIND_POP, 32'sd0);
  endtask

  // random commands; insert bias swings so the queue runs full and empty
  task automatic test_random(input int n_items, input int idle_pct);
    int ins_pct;
    int run_left;
    int r;
    logic [spq_pkg::KIND_W-1:0] kind;
    ins_pct  = 75;
    run_left = $urandom_range(40, 10);
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        ins_pct  = (ins_pct == 75) ? 15 : 75;
        run_left = $urandom_range(40, 10);
      end
      run_left--;
      r = $urandom_range(99);
      if (r < 2)                kind = KIND_NOP;
      else if (r < 5)           kind = spq_pkg::KIND_CLEAR;
      else if (r < 5 + ins_pct) kind = spq_pkg::KIND_INSERT;
      else                      kind = spq_pkg::KIND_POP;
      sender_gap(idle_pct);
      send_op(kind, pick_value());
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    kind_i     = spq_pkg::KIND_INSERT;
    value_i    = '0;
    model_fill = 0;
    mismatches = 0;
    cycles     = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    drain_queue();
    test_random(200, 0);
    drain_queue();
    test_random(200, 84);
    drain_queue();
    test_random(200, 15);
    drain_queue();

    // let any stray report show up
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
test/sorted_priority_queue_test.sv
